>>> rtl/sih_pkg.sv
// ----------------------------------------------------------------------------
// sih_pkg: shared types and constants for the string interning hash table
// Item layouts, table geometry, hash constants and controller states.
// ----------------------------------------------------------------------------
package sih_pkg;

  localparam int TableEntries = 1024;
  localparam int MaxKeyBytes  = 32;
  localparam int SlotW        = $clog2(TableEntries);
  localparam int ByteIdxW     = $clog2(MaxKeyBytes);
  localparam int LenW         = $clog2(MaxKeyBytes + 1);
  localparam int CountW       = $clog2(TableEntries + 1);
  localparam int KeyMemDepth  = TableEntries * MaxKeyBytes;
  localparam int KeyMemAddrW  = $clog2(KeyMemDepth);
  localparam int MetaW        = 1 + LenW + 10;

  localparam logic [31:0] RsStep  = 32'd378551;
  localparam logic [31:0] RsStart = 32'd63689;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFull    = 2'd1;
  localparam logic [1:0] StatusTooLong = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] key_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic       inserted;
    logic [9:0] key_id;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_HASH,
    ST_META_RD,
    ST_META_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FINISH,
    ST_CLEAR
  } state_t;

endpackage

>>> rtl/sih_ram.sv
// ----------------------------------------------------------------------------
// sih_ram: generic single-port synchronous RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module sih_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write-first is not needed; read returns old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/string_interning_hash_table.sv
// ----------------------------------------------------------------------------
// string_interning_hash_table: interns byte strings with sequential ids
// Hashes key bytes, probes a linear-probing table held in RAM.
// ----------------------------------------------------------------------------
// Usage: key bytes enter on the in channel (valid/ready), one item per byte,
// with last on the final byte; cmd is taken from the final byte. Each final
// byte produces one result item on the out channel: found, inserted, key_id,
// status. Non-final bytes produce nothing.
// Each byte is accepted in COLLECT and then passes through HASH for the hash
// multiplies (the multiplier chain is registered between products); the next
// byte is taken only after HASH. On the final byte the controller probes the
// table: per probed slot a metadata RAM read (META_RD, META_CHK), plus a read
// and compare (CMP_RD, CMP_CHK) per key byte in the key-byte RAM. An insert
// copies the key bytewise; the probe run is at most one full table sweep.
// After reset a clearing pass walks all 1024 metadata RAM entries, one entry
// a cycle, during which no item is accepted. The result sits in an
// output register; the block waits there while the receiver stalls and
// takes the next byte once it is taken.
// ----------------------------------------------------------------------------
module string_interning_hash_table (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sih_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sih_pkg::out_item_t   out_data
);

  sih_pkg::state_t state, state_next;

  // Key collection registers.
  logic [7:0]                  key_buf [sih_pkg::MaxKeyBytes];
  logic [sih_pkg::LenW-1:0]    key_len;
  logic                        too_long;
  logic [31:0]                 hash_acc, hash_mul;
  logic [7:0]                  cur_byte;
  logic                        cur_last, cur_cmd;

  // Probe registers.
  logic [sih_pkg::SlotW-1:0]   slot;
  logic [sih_pkg::CountW-1:0]  visited;
  logic [sih_pkg::ByteIdxW-1:0] bidx;
  logic [sih_pkg::CountW-1:0]  entry_count;
  logic [sih_pkg::SlotW-1:0]   clr_idx;

  // RAM ports.
  logic                          meta_we;
  logic [sih_pkg::SlotW-1:0]     meta_addr;
  logic [sih_pkg::MetaW-1:0]     meta_wdata, meta_rdata;
  logic                          kb_we;
  logic [sih_pkg::KeyMemAddrW-1:0] kb_addr;
  logic [7:0]                    kb_rdata;

  logic                        m_valid;
  logic [sih_pkg::LenW-1:0]    m_len;
  logic [9:0]                  m_id;

  assign {m_valid, m_len, m_id} = meta_rdata;

  sih_ram #(.Width(sih_pkg::MetaW), .Depth(sih_pkg::TableEntries)) u_meta (
    .clk(clk), .we(meta_we), .addr(meta_addr), .wdata(meta_wdata), .rdata(meta_rdata)
  );

  sih_ram #(.Width(8), .Depth(sih_pkg::KeyMemDepth)) u_keys (
    .clk(clk), .we(kb_we), .addr(kb_addr), .wdata(key_buf[bidx]), .rdata(kb_rdata)
  );

  // Rolling hash step for the byte in hand.
  logic [31:0] hash_acc_next;
  assign hash_acc_next = hash_acc * hash_mul + {24'd0, cur_byte};

  // Probe helpers.
  logic [sih_pkg::SlotW-1:0] slot_inc;
  logic                      sweep_done;
  logic                      last_byte;
  assign slot_inc   = slot + 1'b1;
  assign sweep_done = (visited + 1'b1) >= sih_pkg::CountW'(sih_pkg::TableEntries);
  assign last_byte  = ({1'b0, bidx} + 1'b1) >= key_len;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sih_pkg::ST_CLEAR:    if (clr_idx == '1) state_next = sih_pkg::ST_COLLECT;
      sih_pkg::ST_COLLECT:  if (in_valid && in_ready) state_next = sih_pkg::ST_HASH;
      sih_pkg::ST_HASH: begin
        if (!cur_last) state_next = sih_pkg::ST_COLLECT;
        else if (too_long) state_next = sih_pkg::ST_FINISH;
        else state_next = sih_pkg::ST_META_RD;
      end
      sih_pkg::ST_META_RD:  state_next = sih_pkg::ST_META_CHK;
      sih_pkg::ST_META_CHK: begin
        if (!m_valid) state_next = cur_cmd ? sih_pkg::ST_COPY_RD : sih_pkg::ST_FINISH;
        else if (m_len == key_len) state_next = sih_pkg::ST_CMP_RD;
        else if (sweep_done) state_next = sih_pkg::ST_FINISH;
        else state_next = sih_pkg::ST_META_RD;
      end
      sih_pkg::ST_CMP_RD:   state_next = sih_pkg::ST_CMP_CHK;
      sih_pkg::ST_CMP_CHK: begin
        if (kb_rdata != key_buf[bidx]) begin
          state_next = sih_pkg::ST_FINISH;
          if (!sweep_done) state_next = sih_pkg::ST_META_RD;
        end else if (last_byte) state_next = sih_pkg::ST_FINISH;
        else state_next = sih_pkg::ST_CMP_RD;
      end
      sih_pkg::ST_COPY_RD:  state_next = sih_pkg::ST_COPY_WR;
      sih_pkg::ST_COPY_WR: begin
        if (last_byte) state_next = sih_pkg::ST_FINISH;
        else state_next = sih_pkg::ST_COPY_RD;
      end
      sih_pkg::ST_FINISH:   if (out_valid && out_ready) state_next = sih_pkg::ST_COLLECT;
      default:              state_next = sih_pkg::ST_CLEAR;
    endcase
  end

  // RAM control.
  always_comb begin
    meta_we    = 1'b0;
    meta_addr  = slot;
    meta_wdata = {1'b1, key_len, entry_count[9:0]};
    kb_we      = 1'b0;
    kb_addr    = {slot, bidx};
    in_ready   = (state == sih_pkg::ST_COLLECT) && !out_valid;
    unique case (state)
      sih_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_addr  = clr_idx;
        meta_wdata = '0;
      end
      sih_pkg::ST_COPY_RD: begin
        kb_we = 1'b1;
        if (last_byte) meta_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sih_pkg::ST_CLEAR;
      clr_idx     <= '0;
      entry_count <= '0;
      key_len     <= '0;
      too_long    <= 1'b0;
      hash_acc    <= '0;
      hash_mul    <= sih_pkg::RsStart;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sih_pkg::ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        sih_pkg::ST_COLLECT: begin
          if (in_valid && in_ready) begin
            cur_byte <= in_data.key_byte;
            cur_last <= in_data.last;
            cur_cmd  <= in_data.cmd;
            if (key_len < sih_pkg::LenW'(sih_pkg::MaxKeyBytes)) begin
              key_buf[key_len[sih_pkg::ByteIdxW-1:0]] <= in_data.key_byte;
              key_len <= key_len + 1'b1;
            end else begin
              too_long <= 1'b1;
            end
          end
        end
        sih_pkg::ST_HASH: begin
          hash_acc <= hash_acc_next;
          hash_mul <= hash_mul * sih_pkg::RsStep;
          out_data <= '{found: 1'b0, inserted: 1'b0, key_id: 10'd0,
                        status: too_long ? sih_pkg::StatusTooLong : sih_pkg::StatusOk};
        end
        sih_pkg::ST_META_RD: begin
          bidx <= '0;
        end
        sih_pkg::ST_META_CHK: begin
          if (!m_valid) begin
            if (cur_cmd) begin
              out_data.inserted <= 1'b1;
              out_data.key_id   <= entry_count[9:0];
            end
          end else if (m_len == key_len) begin
            out_data.key_id <= m_id;
          end else begin
            slot    <= slot_inc;
            visited <= visited + 1'b1;
            if (sweep_done && cur_cmd) out_data.status <= sih_pkg::StatusFull;
          end
        end
        sih_pkg::ST_CMP_CHK: begin
          if (kb_rdata != key_buf[bidx]) begin
            slot    <= slot_inc;
            visited <= visited + 1'b1;
            out_data.key_id <= '0;
            if (sweep_done && cur_cmd) out_data.status <= sih_pkg::StatusFull;
          end else if (last_byte) begin
            out_data.found <= 1'b1;
          end else begin
            bidx <= bidx + 1'b1;
          end
        end
        sih_pkg::ST_COPY_RD: begin
          if (last_byte) entry_count <= entry_count + 1'b1;
        end
        sih_pkg::ST_COPY_WR: begin
          bidx <= bidx + 1'b1;
        end
        default: ;
      endcase
      // Slot and counters are seeded when the hash is final.
      if (state == sih_pkg::ST_HASH && cur_last) begin
        slot    <= hash_acc_next[sih_pkg::SlotW-1:0];
        visited <= '0;
        bidx    <= '0;
      end
      // Result goes out and the key state clears.
      if (state == sih_pkg::ST_FINISH && !out_valid && state_next == sih_pkg::ST_FINISH) begin
        out_valid <= 1'b1;
        key_len   <= '0;
        too_long  <= 1'b0;
        hash_acc  <= '0;
        hash_mul  <= sih_pkg::RsStart;
      end
    end
  end

endmodule
